>>> rtl/core/bbbw_pkg.sv
// Shared types and constants for the boosted box blur block.
`timescale 1ns / 1ps
package bbbw_pkg;

  // Configuration register indexes.
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 18;
  localparam logic [CfgIdxW-1:0] CFG_FADE_GAIN    = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_BOOST_OFFSET = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_BLUR_AMOUNT  = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_BLUR_RADIUS  = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_TILE_WIDTH   = 3'd4;

  // Reset values of the registers that do not reset to zero.
  localparam logic [16:0] FADE_GAIN_RST  = 17'd65536;
  localparam logic [8:0]  TILE_WIDTH_RST = 9'd64;

  // Unit weight in the Q.9 edge weight format.
  localparam int unsigned WeightOne = 512;

  typedef struct packed {
    logic [16:0] fade_gain;
    logic [17:0] boost_offset;
    logic [13:0] blur_amount;
    logic [4:0]  blur_radius;
    logic [8:0]  tile_width;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WRITE,
    ST_ACC,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_DIV,
    ST_DONE
  } back_state_e;

endpackage

>>> rtl/core/boosted_box_blur_weighted.sv
// Top level of the boosted fractional-radius box blur.
`timescale 1ns / 1ps
// Region samples go in through push/full and blurred words come out through
// empty/pop. The front part tracks the raster position and queues each word;
// the back part stores the sample in the line store and, when a full window is
// present, walks it one sample per cycle through a single memory read port.
// A word that yields no result is only written to the line store; one that
// yields a result also passes the window walk, the multiply states and the
// 64-step scaling divider. After reset the line store is cleared, and full
// stays high while it is. Up to two words wait in the queue and one result
// in the output register, so input is taken while a result waits to be
// popped.
module boosted_box_blur_weighted #(
  parameter int unsigned MAX_RADIUS     = 16,
  parameter int unsigned MAX_TILE_WIDTH = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bbbw_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [bbbw_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                          push,
  output logic                          full,
  input  logic signed [31:0]            pixel_value_i,
  input  logic                          region_start_i,
  output logic                          empty,
  input  logic                          pop,
  output logic signed [31:0]            blurred_value_o,
  output logic [7:0]                    out_x_o,
  output logic [7:0]                    out_y_o
);

  localparam int unsigned SlotW  = $clog2(2 * MAX_RADIUS + 1);
  localparam int unsigned ColW   = $clog2(MAX_TILE_WIDTH + 2 * MAX_RADIUS);
  localparam int unsigned JobW   = 32 + 1 + SlotW + ColW + 8 + 8;

  bbbw_pkg::cfg_t   cfg;
  logic             accept, q_full, q_valid, q_pop, clearing, out_valid;
  logic             f_produce, b_produce;
  logic [SlotW-1:0] f_slot, b_slot;
  logic [ColW-1:0]  f_col, b_col;
  logic [7:0]       f_x, f_y, b_x, b_y;
  logic [31:0]      b_pixel, b_value;
  logic [JobW-1:0]  q_wdata, q_rdata;

  assign full   = q_full | clearing;
  assign accept = push & ~full;
  assign empty  = ~out_valid;
  assign blurred_value_o = b_value;

  bbbw_front #(
    .MAX_RADIUS    (MAX_RADIUS),
    .MAX_TILE_WIDTH(MAX_TILE_WIDTH)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .cfg_o         (cfg),
    .accept_i      (accept),
    .region_start_i(region_start_i),
    .job_produce_o (f_produce),
    .job_slot_o    (f_slot),
    .job_col_o     (f_col),
    .job_x_o       (f_x),
    .job_y_o       (f_y)
  );

  assign q_wdata = {pixel_value_i, f_produce, f_slot, f_col, f_x, f_y};
  assign {b_pixel, b_produce, b_slot, b_col, b_x, b_y} = q_rdata;

  bbbw_fifo #(
    .WIDTH(JobW)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (accept),
    .wdata_i(q_wdata),
    .full_o (q_full),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .rdata_o(q_rdata)
  );

  bbbw_back #(
    .MAX_RADIUS    (MAX_RADIUS),
    .MAX_TILE_WIDTH(MAX_TILE_WIDTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .job_valid_i  (q_valid),
    .job_pop_o    (q_pop),
    .job_pixel_i  (b_pixel),
    .job_produce_i(b_produce),
    .job_slot_i   (b_slot),
    .job_col_i    (b_col),
    .job_x_i      (b_x),
    .job_y_i      (b_y),
    .clearing_o   (clearing),
    .out_valid_o  (out_valid),
    .out_pop_i    (pop),
    .out_value_o  (b_value),
    .out_x_o      (out_x_o),
    .out_y_o      (out_y_o)
  );

endmodule

>>> rtl/core/bbbw_fifo.sv
// Two-entry queue that carries words from the front part to the back part.
`timescale 1ns / 1ps
module bbbw_fifo #(
  parameter int unsigned WIDTH = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wptr_q, rptr_q;
  logic [1:0]       cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign rdata_o = mem_q[rptr_q];

  // Pointer and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push_i) wptr_q <= ~wptr_q;
      if (pop_i) rptr_q <= ~rptr_q;
      if (push_i && !pop_i) cnt_q <= cnt_q + 2'd1;
      else if (!push_i && pop_i) cnt_q <= cnt_q - 2'd1;
    end
  end

  // Storage.
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= wdata_i;
  end

endmodule

>>> rtl/core/bbbw_front.sv
// Front part: configuration registers and the raster position of each sample.
`timescale 1ns / 1ps
module bbbw_front #(
  parameter int unsigned MAX_RADIUS     = 16,
  parameter int unsigned MAX_TILE_WIDTH = 256
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [bbbw_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  logic [bbbw_pkg::CfgDataW-1:0]        cfg_wdata_i,
  output bbbw_pkg::cfg_t                       cfg_o,
  input  logic                                 accept_i,
  input  logic                                 region_start_i,
  output logic                                 job_produce_o,
  output logic [$clog2(2*MAX_RADIUS+1)-1:0]    job_slot_o,
  output logic [$clog2(MAX_TILE_WIDTH+2*MAX_RADIUS)-1:0] job_col_o,
  output logic [7:0]                           job_x_o,
  output logic [7:0]                           job_y_o
);

  localparam int unsigned RowSlots  = 2 * MAX_RADIUS + 1;
  localparam int unsigned RowStride = MAX_TILE_WIDTH + 2 * MAX_RADIUS;
  localparam int unsigned SlotW     = $clog2(RowSlots);
  localparam int unsigned ColW      = $clog2(RowStride);
  localparam int unsigned RadW      = $clog2(MAX_RADIUS + 1);
  localparam int unsigned SpanW     = RadW + 1;

  bbbw_pkg::cfg_t   cfg_q;
  logic [ColW-1:0]  col_q, col_d, col_c;
  logic [SlotW-1:0] slot_q, slot_d, slot_c;
  logic [SlotW-1:0] rows_q, rows_d, rows_c;
  logic [7:0]       rowmod_q, rowmod_d, rowmod_c;
  logic [RadW-1:0]  radius;
  logic [SpanW-1:0] span;
  logic [ColW:0]    eff_w, region_w, col_inc;
  logic [31:0]      dx;

  assign cfg_o = cfg_q;

  // Register writes; unknown indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fade_gain    <= bbbw_pkg::FADE_GAIN_RST;
      cfg_q.boost_offset <= '0;
      cfg_q.blur_amount  <= '0;
      cfg_q.blur_radius  <= '0;
      cfg_q.tile_width   <= bbbw_pkg::TILE_WIDTH_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bbbw_pkg::CFG_FADE_GAIN:    cfg_q.fade_gain    <= cfg_wdata_i[16:0];
        bbbw_pkg::CFG_BOOST_OFFSET: cfg_q.boost_offset <= cfg_wdata_i[17:0];
        bbbw_pkg::CFG_BLUR_AMOUNT:  cfg_q.blur_amount  <= cfg_wdata_i[13:0];
        bbbw_pkg::CFG_BLUR_RADIUS:  cfg_q.blur_radius  <= cfg_wdata_i[4:0];
        bbbw_pkg::CFG_TILE_WIDTH:   cfg_q.tile_width   <= cfg_wdata_i[8:0];
        default: ;
      endcase
    end
  end

  // Effective radius and region width, and the position of this sample.
  always_comb begin
    if (int'(cfg_q.blur_radius) > MAX_RADIUS) radius = RadW'(MAX_RADIUS);
    else radius = RadW'(cfg_q.blur_radius);
    span = {radius, 1'b0};
    if (cfg_q.tile_width == 9'd0) eff_w = (ColW+1)'(1);
    else if (int'(cfg_q.tile_width) > MAX_TILE_WIDTH) eff_w = (ColW+1)'(MAX_TILE_WIDTH);
    else eff_w = (ColW+1)'(cfg_q.tile_width);
    region_w = eff_w + (ColW+1)'(span);

    col_c    = region_start_i ? '0 : col_q;
    slot_c   = region_start_i ? '0 : slot_q;
    rows_c   = region_start_i ? '0 : rows_q;
    rowmod_c = region_start_i ? '0 : rowmod_q;

    job_produce_o = (int'(rows_c) >= int'(span)) && (int'(col_c) >= int'(span));
    job_slot_o    = slot_c;
    job_col_o     = col_c;
    dx            = 32'(col_c) - 32'(span);
    job_x_o       = dx[7:0];
    job_y_o       = rowmod_c - 8'(span);

    col_inc  = (ColW+1)'(col_c) + (ColW+1)'(1);
    col_d    = col_inc[ColW-1:0];
    slot_d   = slot_c;
    rows_d   = rows_c;
    rowmod_d = rowmod_c;
    if (col_inc >= region_w) begin
      col_d    = '0;
      slot_d   = (int'(slot_c) == RowSlots - 1) ? '0 : slot_c + SlotW'(1);
      rows_d   = (int'(rows_c) < 2 * MAX_RADIUS) ? rows_c + SlotW'(1) : rows_c;
      rowmod_d = rowmod_c + 8'd1;
    end
  end

  // Position counters advance on each accepted word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q    <= '0;
      slot_q   <= '0;
      rows_q   <= '0;
      rowmod_q <= '0;
    end else if (accept_i) begin
      col_q    <= col_d;
      slot_q   <= slot_d;
      rows_q   <= rows_d;
      rowmod_q <= rowmod_d;
    end
  end

endmodule

>>> rtl/core/bbbw_back.sv
// Back part: line store, window accumulation, scaling divider and result register.
`timescale 1ns / 1ps
module bbbw_back #(
  parameter int unsigned MAX_RADIUS     = 16,
  parameter int unsigned MAX_TILE_WIDTH = 256
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  bbbw_pkg::cfg_t                       cfg_i,
  input  logic                                 job_valid_i,
  output logic                                 job_pop_o,
  input  logic [31:0]                          job_pixel_i,
  input  logic                                 job_produce_i,
  input  logic [$clog2(2*MAX_RADIUS+1)-1:0]    job_slot_i,
  input  logic [$clog2(MAX_TILE_WIDTH+2*MAX_RADIUS)-1:0] job_col_i,
  input  logic [7:0]                           job_x_i,
  input  logic [7:0]                           job_y_i,
  output logic                                 clearing_o,
  output logic                                 out_valid_o,
  input  logic                                 out_pop_i,
  output logic [31:0]                          out_value_o,
  output logic [7:0]                           out_x_o,
  output logic [7:0]                           out_y_o
);

  localparam int unsigned RowSlots  = 2 * MAX_RADIUS + 1;
  localparam int unsigned RowStride = MAX_TILE_WIDTH + 2 * MAX_RADIUS;
  localparam int unsigned Depth     = RowSlots * RowStride;
  localparam int unsigned AddrW     = $clog2(Depth);
  localparam int unsigned SlotW     = $clog2(RowSlots);
  localparam int unsigned ColW      = $clog2(RowStride);
  localparam int unsigned RadW      = $clog2(MAX_RADIUS + 1);
  localparam int unsigned SpanW     = RadW + 1;

  bbbw_pkg::back_state_e state_q, state_d;

  // Line store.
  logic [31:0]      mem_q [Depth];
  logic             mem_we;
  logic [AddrW-1:0] waddr, raddr;
  logic [31:0]      wdata, rdata_q;

  // Latched word and window iterators.
  logic [31:0]      pix_q;
  logic             prod_q;
  logic [SlotW-1:0] slot_q, rs_q;
  logic [ColW-1:0]  col_q, rc_q, c0_q;
  logic [7:0]       x_q, y_q;
  logic [SpanW-1:0] di_q, dj_q;
  logic             issue_done_q;
  logic [AddrW-1:0] clr_q;

  // Accumulation pipeline.
  logic               v1_q, v2_q;
  logic [18:0]        w1_q;
  logic signed [52:0] p2_q;
  logic signed [63:0] acc_q;
  logic signed [32:0] samp;

  // Scaling.
  logic        neg_q;
  logic [39:0] plo_q;
  logic [29:0] d_q;
  logic [63:0] num_q;
  logic [29:0] rem_q;
  logic [5:0]  cnt_q;
  logic [63:0] mag, mag_rnd;
  logic [45:0] m16;
  logic [30:0] rem_sh;
  logic        q_bit;
  logic [31:0] result;

  // Window shape.
  logic [RadW-1:0]  radius;
  logic [SpanW-1:0] span;
  logic [9:0]       e9, fi, fj;
  logic [18:0]      wgt;
  logic [SlotW-1:0] rs_start;
  int               e9_raw;

  logic out_valid_q;
  logic [31:0] out_value_q;
  logic [7:0]  out_x_q, out_y_q;

  assign out_valid_o = out_valid_q;
  assign out_value_o = out_value_q;
  assign out_x_o     = out_x_q;
  assign out_y_o     = out_y_q;
  assign clearing_o  = (state_q == bbbw_pkg::ST_CLEAR);

  // Edge weight, per-sample weight, read address, window start row and boosted sample.
  always_comb begin
    if (int'(cfg_i.blur_radius) > MAX_RADIUS) radius = RadW'(MAX_RADIUS);
    else radius = RadW'(cfg_i.blur_radius);
    span   = {radius, 1'b0};
    e9_raw = int'(bbbw_pkg::WeightOne) + int'(cfg_i.blur_amount)
             - int'(bbbw_pkg::WeightOne) * int'(radius);
    if (e9_raw < 0) e9 = 10'd0;
    else if (e9_raw > int'(bbbw_pkg::WeightOne)) e9 = 10'(bbbw_pkg::WeightOne);
    else e9 = 10'(e9_raw);
    fi  = (di_q == '0 || di_q == span) ? e9 : 10'(bbbw_pkg::WeightOne);
    fj  = (dj_q == '0 || dj_q == span) ? e9 : 10'(bbbw_pkg::WeightOne);
    wgt = {9'b0, fi} * {9'b0, fj};
    raddr = AddrW'(int'(rs_q) * RowStride + int'(rc_q));
    if (int'(slot_q) >= int'(span)) rs_start = SlotW'(int'(slot_q) - int'(span));
    else rs_start = SlotW'(int'(slot_q) + RowSlots - int'(span));
    samp = $signed({rdata_q[31], rdata_q}) + $signed({15'b0, cfg_i.boost_offset});
  end

  // Magnitude rounding, one restoring divide step and the saturated result.
  always_comb begin
    mag     = acc_q[63] ? 64'(-acc_q) : 64'(acc_q);
    mag_rnd = mag + 64'd131072;
    m16     = mag_rnd[63:18];
    rem_sh  = {rem_q, num_q[63]};
    q_bit   = (rem_sh >= {1'b0, d_q});
    if (neg_q) begin
      if (num_q > 64'h8000_0000) result = 32'h8000_0000;
      else result = 32'd0 - num_q[31:0];
    end else begin
      if (num_q > 64'h7fff_ffff) result = 32'h7fff_ffff;
      else result = num_q[31:0];
    end
  end

  // Sequencer next state and memory write control.
  always_comb begin
    state_d   = state_q;
    job_pop_o = 1'b0;
    mem_we    = 1'b0;
    waddr     = AddrW'(int'(slot_q) * RowStride + int'(col_q));
    wdata     = pix_q;
    case (state_q)
      bbbw_pkg::ST_CLEAR: begin
        mem_we = 1'b1;
        waddr  = clr_q;
        wdata  = '0;
        if (int'(clr_q) == Depth - 1) state_d = bbbw_pkg::ST_IDLE;
      end
      bbbw_pkg::ST_IDLE: begin
        if (job_valid_i) begin
          job_pop_o = 1'b1;
          state_d   = bbbw_pkg::ST_WRITE;
        end
      end
      bbbw_pkg::ST_WRITE: begin
        mem_we  = 1'b1;
        state_d = prod_q ? bbbw_pkg::ST_ACC : bbbw_pkg::ST_IDLE;
      end
      bbbw_pkg::ST_ACC: begin
        if (issue_done_q && !v1_q && !v2_q) state_d = bbbw_pkg::ST_MUL_LO;
      end
      bbbw_pkg::ST_MUL_LO: state_d = bbbw_pkg::ST_MUL_HI;
      bbbw_pkg::ST_MUL_HI: state_d = bbbw_pkg::ST_DIV;
      bbbw_pkg::ST_DIV: begin
        if (cnt_q == 6'd63) state_d = bbbw_pkg::ST_DONE;
      end
      bbbw_pkg::ST_DONE: begin
        if (!out_valid_q) state_d = bbbw_pkg::ST_IDLE;
      end
      default: state_d = bbbw_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= bbbw_pkg::ST_CLEAR;
    else state_q <= state_d;
  end

  // Memory with registered read.
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[waddr] <= wdata;
    rdata_q <= mem_q[raddr];
  end

  // Control registers: clear sweep, issue flags, pipeline valids, result valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q        <= '0;
      issue_done_q <= 1'b1;
      v1_q         <= 1'b0;
      v2_q         <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (state_q == bbbw_pkg::ST_CLEAR) clr_q <= clr_q + AddrW'(1);
      v1_q <= (state_q == bbbw_pkg::ST_ACC) && !issue_done_q;
      v2_q <= v1_q;
      if (state_q == bbbw_pkg::ST_WRITE) issue_done_q <= 1'b0;
      else if (state_q == bbbw_pkg::ST_ACC && !issue_done_q && di_q == span && dj_q == span)
        issue_done_q <= 1'b1;
      if (state_q == bbbw_pkg::ST_DONE && !out_valid_q) out_valid_q <= 1'b1;
      else if (out_pop_i) out_valid_q <= 1'b0;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    w1_q <= wgt;
    p2_q <= samp * $signed({1'b0, w1_q});
    if (v2_q) acc_q <= acc_q + {{11{p2_q[52]}}, p2_q};
    case (state_q)
      bbbw_pkg::ST_IDLE: begin
        pix_q  <= job_pixel_i;
        prod_q <= job_produce_i;
        slot_q <= job_slot_i;
        col_q  <= job_col_i;
        x_q    <= job_x_i;
        y_q    <= job_y_i;
      end
      bbbw_pkg::ST_WRITE: begin
        rs_q  <= rs_start;
        rc_q  <= col_q - ColW'(span);
        c0_q  <= col_q - ColW'(span);
        di_q  <= '0;
        dj_q  <= '0;
        acc_q <= '0;
      end
      bbbw_pkg::ST_ACC: begin
        if (!issue_done_q) begin
          if (dj_q == span) begin
            dj_q <= '0;
            rc_q <= c0_q;
            di_q <= di_q + SpanW'(1);
            rs_q <= (int'(rs_q) == RowSlots - 1) ? '0 : rs_q + SlotW'(1);
          end else begin
            dj_q <= dj_q + SpanW'(1);
            rc_q <= rc_q + ColW'(1);
          end
        end
      end
      bbbw_pkg::ST_MUL_LO: begin
        neg_q <= acc_q[63];
        plo_q <= m16[22:0] * cfg_i.fade_gain;
        d_q   <= 30'(({15'b0, cfg_i.blur_amount} + 15'd256)
                     * ({15'b0, cfg_i.blur_amount} + 15'd256));
      end
      bbbw_pkg::ST_MUL_HI: begin
        num_q <= ({24'b0, 40'(m16[45:23] * cfg_i.fade_gain)} << 23)
                 + {24'b0, plo_q} + {35'b0, d_q[29:1]};
        rem_q <= '0;
        cnt_q <= '0;
      end
      bbbw_pkg::ST_DIV: begin
        rem_q <= q_bit ? 30'(rem_sh - {1'b0, d_q}) : rem_sh[29:0];
        num_q <= {num_q[62:0], q_bit};
        cnt_q <= cnt_q + 6'd1;
      end
      bbbw_pkg::ST_DONE: begin
        if (!out_valid_q) begin
          out_value_q <= result;
          out_x_q     <= x_q;
          out_y_q     <= y_q;
        end
      end
      default: ;
    endcase
  end

endmodule

>>> bench/tb_boosted_box_blur_weighted.sv
// Self-checking testbench for the boosted fractional-radius box blur block.
`timescale 1ns / 1ps
module tb_boosted_box_blur_weighted;

  localparam int unsigned RowSlots  = 33;
  localparam int unsigned RowStride = 288;
  localparam int unsigned WatchdogLimit = 60000;

  // Register indexes that no register answers to.
  localparam logic [bbbw_pkg::CfgIdxW-1:0] CfgIdxSpareLo = 3'd5;
  localparam logic [bbbw_pkg::CfgIdxW-1:0] CfgIdxSpareHi = 3'd7;

  typedef struct {
    logic signed [31:0] value;
    logic [7:0]         x;
    logic [7:0]         y;
  } blur_word_t;

  // Predicts the blurred words from the accepted samples and checks the results.
  class blur_scoreboard;
    int unsigned fade_gain, boost_offset, blur_amount, blur_radius, tile_width;
    int          line_mem[RowSlots*RowStride];
    int unsigned col_pos, row_slot, rows_seen, row_num;
    blur_word_t  expected_q[$];
    int unsigned mismatches;

    function new();
      fade_gain    = bbbw_pkg::FADE_GAIN_RST;
      boost_offset = 0;
      blur_amount  = 0;
      blur_radius  = 0;
      tile_width   = bbbw_pkg::TILE_WIDTH_RST;
      col_pos      = 0;
      row_slot     = 0;
      rows_seen    = 0;
      row_num      = 0;
      mismatches   = 0;
      foreach (line_mem[i]) line_mem[i] = 0;
    endfunction

    function void write_reg(logic [bbbw_pkg::CfgIdxW-1:0] idx,
                            logic [bbbw_pkg::CfgDataW-1:0] data);
      case (idx)
        bbbw_pkg::CFG_FADE_GAIN:    fade_gain    = data[16:0];
        bbbw_pkg::CFG_BOOST_OFFSET: boost_offset = data[17:0];
        bbbw_pkg::CFG_BLUR_AMOUNT:  blur_amount  = data[13:0];
        bbbw_pkg::CFG_BLUR_RADIUS:  blur_radius  = data[4:0];
        bbbw_pkg::CFG_TILE_WIDTH:   tile_width   = data[8:0];
        default: ;
      endcase
    endfunction

    // Normalizes the weighted window sum and saturates it to 32 bits.
    function logic [31:0] scale_sum(longint acc);
      longint unsigned mag, m16, dnm, q;
      bit neg;
      neg = acc < 0;
      mag = neg ? -acc : acc;
      m16 = (mag + (64'd1 << 17)) >> 18;
      dnm = (256 + blur_amount) * (256 + blur_amount);
      q = (m16 * fade_gain + dnm / 2) / dnm;
      if (neg) begin
        if (q > 64'h8000_0000) q = 64'h8000_0000;
        return 32'(64'h1_0000_0000 - q);
      end
      if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
      return q[31:0];
    endfunction

    function void note_word(logic signed [31:0] px, logic start);
      int unsigned rad, span, region_w, slot, c;
      longint e9, fi, fj, acc, s;
      blur_word_t w;
      rad = (blur_radius > 16) ? 16 : blur_radius;
      span = 2 * rad;
      region_w = (tile_width == 0) ? 1 : ((tile_width > 256) ? 256 : tile_width);
      region_w += span;
      if (start) begin
        col_pos = 0;
        row_slot = 0;
        rows_seen = 0;
        row_num = 0;
      end
      line_mem[row_slot*RowStride + col_pos] = px;
      if (rows_seen >= span && col_pos >= span) begin
        e9 = longint'(bbbw_pkg::WeightOne) + blur_amount
             - longint'(bbbw_pkg::WeightOne) * rad;
        if (e9 < 0) e9 = 0;
        if (e9 > bbbw_pkg::WeightOne) e9 = bbbw_pkg::WeightOne;
        acc = 0;
        for (int unsigned di = 0; di <= span; di++) begin
          slot = (row_slot + RowSlots - (span - di)) % RowSlots;
          fi = (di == 0 || di == span) ? e9 : bbbw_pkg::WeightOne;
          for (int unsigned dj = 0; dj <= span; dj++) begin
            c = col_pos - span + dj;
            fj = (dj == 0 || dj == span) ? e9 : bbbw_pkg::WeightOne;
            s = longint'(line_mem[slot*RowStride + c]) + boost_offset;
            acc += s * (fi * fj);
          end
        end
        w.value = scale_sum(acc);
        w.x = 8'(col_pos - span);
        w.y = 8'(row_num + 256 - span);
        expected_q.push_back(w);
      end
      col_pos++;
      if (col_pos >= region_w) begin
        col_pos = 0;
        row_slot = (row_slot + 1) % RowSlots;
        if (rows_seen < 32) rows_seen++;
        row_num = (row_num + 1) & 8'hFF;
      end
    endfunction

    function void check_result(logic signed [31:0] value, logic [7:0] x, logic [7:0] y);
      blur_word_t w;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: value %0d x %0d y %0d", value, x, y);
        return;
      end
      w = expected_q.pop_front();
      if (value !== w.value || x !== w.x || y !== w.y) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected value %0d x %0d y %0d, got value %0d x %0d y %0d",
                   w.value, w.x, w.y, value, x, y);
      end
    endfunction
  endclass

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          cfg_we_i = 1'b0;
  logic [bbbw_pkg::CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [bbbw_pkg::CfgDataW-1:0] cfg_wdata_i = '0;
  logic                          push = 1'b0;
  logic                          full;
  logic signed [31:0]            pixel_value_i = '0;
  logic                          region_start_i = 1'b0;
  logic                          empty;
  logic                          pop = 1'b0;
  logic signed [31:0]            blurred_value_o;
  logic [7:0]                    out_x_o, out_y_o;

  blur_scoreboard sb = new();
  int unsigned send_idle_pct = 29;
  int unsigned recv_idle_pct = 65;
  int unsigned quiet_cycles = 0;

  boosted_box_blur_weighted i_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .push, .full, .pixel_value_i, .region_start_i,
    .empty, .pop, .blurred_value_o, .out_x_o, .out_y_o
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Random receiver stalls.
  always @(negedge clk_i) begin
    pop <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Monitor both handshakes and guard against a hang.
  always @(posedge clk_i) begin
    if (push && !full || pop && !empty) quiet_cycles = 0;
    else quiet_cycles++;
    if (push && !full) sb.note_word(pixel_value_i, region_start_i);
    if (pop && !empty) sb.check_result(blurred_value_o, out_x_o, out_y_o);
    if (quiet_cycles >= WatchdogLimit) begin
      $display("boosted_box_blur_weighted regression: fail");
      $finish;
    end
  end

  task automatic send_word(logic signed [31:0] px, logic start);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      @(negedge clk_i);
      push <= 1'b0;
    end
    @(negedge clk_i);
    push <= 1'b1;
    pixel_value_i <= px;
    region_start_i <= start;
    do @(posedge clk_i); while (full);
  endtask

  // Stop sending and wait until every expected word has come back.
  task automatic drain();
    @(negedge clk_i);
    push <= 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [bbbw_pkg::CfgIdxW-1:0] idx,
                           logic [bbbw_pkg::CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    sb.write_reg(idx, data);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic signed [31:0] rand_pixel();
    case ($urandom_range(0, 9))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return 32'($urandom_range(0, 4095)) - 2048;
      default: return $urandom;
    endcase
  endfunction

  // One phase of random settings and a random stream.
  task automatic random_phase(int unsigned n_words);
    write_reg(bbbw_pkg::CFG_FADE_GAIN,
              ($urandom_range(0, 3) == 0) ? 18'd65536 : 18'($urandom_range(0, 131071)));
    write_reg(bbbw_pkg::CFG_BOOST_OFFSET, 18'($urandom_range(0, 262143)));
    write_reg(bbbw_pkg::CFG_BLUR_AMOUNT,
              18'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 16383)
                                               : $urandom_range(0, 1200)));
    write_reg(bbbw_pkg::CFG_BLUR_RADIUS,
              18'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 31)
                                               : $urandom_range(0, 3)));
    write_reg(bbbw_pkg::CFG_TILE_WIDTH,
              18'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 511)
                                               : $urandom_range(0, 16)));
    for (int unsigned i = 0; i < n_words; i++)
      send_word(rand_pixel(), (i == 0) ? ($urandom_range(0, 3) != 0)
                                       : ($urandom_range(0, 99) == 0));
    drain();
  endtask

  initial begin
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed words at reset settings, the first ones before any region start.
    send_word(32'sh7FFF_FFFF, 1'b0);
    send_word(32'sh8000_0000, 1'b0);
    send_word(32'sh0000_0000, 1'b1);
    send_word(-32'sd1, 1'b0);
    send_word(32'sh0001_0000, 1'b0);
    send_word(32'sh0000_8000, 1'b0);
    drain();
    write_reg(bbbw_pkg::CFG_BOOST_OFFSET, 18'd131072);
    write_reg(CfgIdxSpareLo, 18'h3FFFF);
    write_reg(CfgIdxSpareHi, 18'h3FFFF);
    send_word(32'sh7FFF_FFFF, 1'b1);
    send_word(32'sh8000_0000, 1'b0);
    drain();
    write_reg(bbbw_pkg::CFG_FADE_GAIN, 18'd0);
    send_word(32'sh7FFF_FFFF, 1'b0);
    drain();

    // One column per row: many rows, so out_y wraps and the row count fills up.
    write_reg(bbbw_pkg::CFG_FADE_GAIN, 18'd65536);
    write_reg(bbbw_pkg::CFG_TILE_WIDTH, 18'd1);
    for (int i = 0; i < 300; i++) send_word(rand_pixel(), i == 0);
    drain();

    // Largest radius and blur, switched in mid-region.
    write_reg(bbbw_pkg::CFG_BLUR_AMOUNT, 18'd8192);
    write_reg(bbbw_pkg::CFG_BLUR_RADIUS, 18'd16);
    for (int i = 0; i < 70; i++) send_word(rand_pixel(), 1'b0);
    drain();
    write_reg(bbbw_pkg::CFG_BLUR_RADIUS, 18'd31);
    write_reg(bbbw_pkg::CFG_BLUR_AMOUNT, 18'd16383);
    write_reg(bbbw_pkg::CFG_TILE_WIDTH, 18'd0);
    for (int i = 0; i < 34; i++) send_word(rand_pixel(), 1'b0);
    drain();
    write_reg(bbbw_pkg::CFG_BLUR_RADIUS, 18'd0);
    write_reg(bbbw_pkg::CFG_TILE_WIDTH, 18'd511);
    for (int i = 0; i < 20; i++) send_word(rand_pixel(), i == 0);
    drain();

    // Random phases under the three idling patterns.
    for (int m = 0; m < 3; m++) begin
      send_idle_pct = (m == 0) ? 29 : (m == 1) ? 65 : 0;
      recv_idle_pct = (m == 0) ? 65 : (m == 1) ? 29 : 0;
      for (int p = 0; p < 3; p++) random_phase(100);
    end

    drain();
    repeat (100) @(negedge clk_i);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0)
      $display("boosted_box_blur_weighted regression: pass");
    else
      $display("boosted_box_blur_weighted regression: fail");
    $finish;
  end

endmodule
